[hw/rtl/uyvy_pair_to_rgb_macros.svh]
// ----------------------------------------------------------------------------
// uyvy_pair_to_rgb assertion macros
// Short wrappers for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef UYVY_PAIR_TO_RGB_MACROS_SVH
`define UYVY_PAIR_TO_RGB_MACROS_SVH

// Implication checked outside reset.
`define UPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent, outside reset.
`define UPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent, also through reset.
`define UPR_ASSERT_RST(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/upr_pkg.sv]
// ----------------------------------------------------------------------------
// upr_pkg
// Types, coefficient constants and term tables for the UYVY to RGB converter.
// ----------------------------------------------------------------------------
package upr_pkg;

  localparam int TermW = 16;
  localparam int SumW  = 18;

  // Terms in 1/1000 of a 1/32 unit: slope per code and offset
  localparam int LUMA_SLOPE = 37248;
  localparam int LUMA_OFS_B = -8861696;
  localparam int LUMA_OFS_G = 4335616;
  localparam int LUMA_OFS_R = -7133184;
  localparam int CB_SLOPE_B = 64576;
  localparam int CB_SLOPE_G = -12512;
  localparam int CR_SLOPE_G = -26016;
  localparam int CR_SLOPE_R = 51072;

  localparam logic [7:0] GREY_CHROMA = 8'd128;

  // Config register indexes
  localparam logic REG_LUMA_ONLY = 1'b0;

  typedef logic signed [TermW-1:0] term_t;
  typedef term_t term_tab_t [256];

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic [7:0] cb;
    logic [7:0] y0;
    logic [7:0] cr;
    logic [7:0] y1;
    logic       one_pixel;
  } grp_t;

  // Per-code term in 1/32 units, rounded to nearest; built at elaboration
  function automatic term_tab_t build_tab(input int slope, input int ofs);
    term_tab_t tab;
    int        num;
    int        rnd;
    for (int i = 0; i < 256; i++) begin
      num    = slope * i + ofs;
      rnd    = (num + 100000500) / 1000 - 100000;
      tab[i] = TermW'(rnd);
    end
    return tab;
  endfunction

  localparam term_tab_t LUMA_B_TAB = build_tab(LUMA_SLOPE, LUMA_OFS_B);
  localparam term_tab_t LUMA_G_TAB = build_tab(LUMA_SLOPE, LUMA_OFS_G);
  localparam term_tab_t LUMA_R_TAB = build_tab(LUMA_SLOPE, LUMA_OFS_R);
  localparam term_tab_t CB_B_TAB   = build_tab(CB_SLOPE_B, 0);
  localparam term_tab_t CB_G_TAB   = build_tab(CB_SLOPE_G, 0);
  localparam term_tab_t CR_G_TAB   = build_tab(CR_SLOPE_G, 0);
  localparam term_tab_t CR_R_TAB   = build_tab(CR_SLOPE_R, 0);

endpackage

[hw/rtl/upr_in_if.sv]
// ----------------------------------------------------------------------------
// upr_in_if
// Input channel: one UYVY group per beat.
// ----------------------------------------------------------------------------
interface upr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cb_byte;
  logic [7:0] y_first;
  logic [7:0] cr_byte;
  logic [7:0] y_second;
  logic       one_pixel;

  modport source (output valid, cb_byte, y_first, cr_byte, y_second, one_pixel,
                  input ready);
  modport sink   (input valid, cb_byte, y_first, cr_byte, y_second, one_pixel,
                  output ready);
endinterface

[hw/rtl/upr_out_if.sv]
// ----------------------------------------------------------------------------
// upr_out_if
// Result channel: two RGB pixels per beat.
// ----------------------------------------------------------------------------
interface upr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_first;
  logic [7:0] green_first;
  logic [7:0] red_first;
  logic [7:0] blue_second;
  logic [7:0] green_second;
  logic [7:0] red_second;
  logic       second_valid;

  modport source (output valid, blue_first, green_first, red_first, blue_second,
                  green_second, red_second, second_valid, input ready);
  modport sink   (input valid, blue_first, green_first, red_first, blue_second,
                  green_second, red_second, second_valid, output ready);
endinterface

[hw/rtl/upr_cfg.sv]
// ----------------------------------------------------------------------------
// upr_cfg
// APB-style register port holding the luma-only mode bit.
// ----------------------------------------------------------------------------
module upr_cfg
  import upr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        luma_only
);

  logic luma_only_r;
  logic luma_only_nxt;
  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_LUMA_ONLY);

  // write decode
  always_comb begin
    luma_only_nxt = luma_only_r;
    if (wr_hit) begin
      luma_only_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      luma_only_r <= 1'b0;
    end else begin
      luma_only_r <= luma_only_nxt;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LUMA_ONLY) begin
      prdata = {31'b0, luma_only_r};
    end
  end

  assign luma_only = luma_only_r;

endmodule

[hw/rtl/upr_pixel.sv]
// ----------------------------------------------------------------------------
// upr_pixel
// One pixel: luma term lookup, channel sums, floor shift and clamp.
// ----------------------------------------------------------------------------
module upr_pixel
  import upr_pkg::*;
(
  input  logic [7:0] luma,
  input  term_t      cb_b,
  input  term_t      cb_g,
  input  term_t      cr_g,
  input  term_t      cr_r,
  output rgb_t       pix
);

  term_t                  yb;
  term_t                  yg;
  term_t                  yr;
  logic signed [SumW-1:0] sum_b;
  logic signed [SumW-1:0] sum_g;
  logic signed [SumW-1:0] sum_r;

  // Floor divide by 32, then clamp to 0..255
  function automatic logic [7:0] finish(input logic signed [SumW-1:0] sum);
    logic signed [SumW-6:0] q;
    q = (SumW-5)'(sum >>> 5);
    priority if (q < 0) begin
      return 8'd0;
    end else if (q > 255) begin
      return 8'd255;
    end else begin
      return q[7:0];
    end
  endfunction

  // luma terms
  assign yb = LUMA_B_TAB[luma];
  assign yg = LUMA_G_TAB[luma];
  assign yr = LUMA_R_TAB[luma];

  // channel sums
  assign sum_b = SumW'(yb) + SumW'(cb_b);
  assign sum_g = SumW'(yg) + SumW'(cb_g) + SumW'(cr_g);
  assign sum_r = SumW'(yr) + SumW'(cr_r);

  assign pix.blue  = finish(sum_b);
  assign pix.green = finish(sum_g);
  assign pix.red   = finish(sum_r);

endmodule

[hw/rtl/uyvy_pair_to_rgb.sv]
// ----------------------------------------------------------------------------
// uyvy_pair_to_rgb
// UYVY 4:2:2 group to two BT.601 RGB pixels, fixed-point with 1/32 terms.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; table lookup, sums and
//   clamp sit between them.
// Throughput: one group per cycle unless out_beat.ready stalls the two-register pipeline.
// Reset: synchronous active-low rst_n empties both stages and clears luma_only.
`include "uyvy_pair_to_rgb_macros.svh"

module uyvy_pair_to_rgb
  import upr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  upr_in_if.sink      in_beat,
  upr_out_if.source   out_beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic luma_only;
  logic s1_v_r;
  grp_t s1_r;
  grp_t s1_nxt;
  logic out_v_r;
  logic out_load;
  logic s1_load;
  rgb_t pix0;
  rgb_t pix1;
  rgb_t pix0_r;
  rgb_t pix1_r;
  rgb_t pix1_nxt;
  logic sec_v_r;
  term_t cb_b;
  term_t cb_g;
  term_t cr_g;
  term_t cr_r;

  upr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .luma_only (luma_only)
  );

  // pipeline advance
  assign out_load       = !out_v_r || out_beat.ready;
  assign s1_load        = !s1_v_r || out_load;
  assign in_beat.ready  = s1_load;

  // input capture, chroma forced to grey in luma-only mode
  always_comb begin
    s1_nxt.cb        = luma_only ? GREY_CHROMA : in_beat.cb_byte;
    s1_nxt.y0        = in_beat.y_first;
    s1_nxt.cr        = luma_only ? GREY_CHROMA : in_beat.cr_byte;
    s1_nxt.y1        = in_beat.y_second;
    s1_nxt.one_pixel = in_beat.one_pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_load) begin
      s1_v_r <= in_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_beat.valid) begin
      s1_r <= s1_nxt;
    end
  end

  // shared chroma terms
  assign cb_b = CB_B_TAB[s1_r.cb];
  assign cb_g = CB_G_TAB[s1_r.cb];
  assign cr_g = CR_G_TAB[s1_r.cr];
  assign cr_r = CR_R_TAB[s1_r.cr];

  upr_pixel u_pix0 (
    .luma (s1_r.y0),
    .cb_b (cb_b),
    .cb_g (cb_g),
    .cr_g (cr_g),
    .cr_r (cr_r),
    .pix  (pix0)
  );

  upr_pixel u_pix1 (
    .luma (s1_r.y1),
    .cb_b (cb_b),
    .cb_g (cb_g),
    .cr_g (cr_g),
    .cr_r (cr_r),
    .pix  (pix1)
  );

  // odd tail zeroes the second pixel
  assign pix1_nxt = s1_r.one_pixel ? '0 : pix1;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_v_r) begin
      pix0_r  <= pix0;
      pix1_r  <= pix1_nxt;
      sec_v_r <= !s1_r.one_pixel;
    end
  end

  assign out_beat.valid        = out_v_r;
  assign out_beat.blue_first   = pix0_r.blue;
  assign out_beat.green_first  = pix0_r.green;
  assign out_beat.red_first    = pix0_r.red;
  assign out_beat.blue_second  = pix1_r.blue;
  assign out_beat.green_second = pix1_r.green;
  assign out_beat.red_second   = pix1_r.red;
  assign out_beat.second_valid = sec_v_r;

  // checks
  `UPR_ASSERT_NXT(a_s1_moves, clk, rst_n, s1_v_r && out_load, out_v_r, "stage 1 beat lost")
  `UPR_ASSERT_IMP(a_tail_zero, clk, rst_n, out_v_r && !sec_v_r, pix1_r == '0, "tail not zeroed")
  `UPR_ASSERT_IMP(a_no_overrun, clk, rst_n, in_beat.ready && s1_v_r, out_load, "stage 1 overrun")
  `UPR_ASSERT_RST(a_rst_empty, clk, !rst_n, !out_v_r && !s1_v_r, "pipeline not empty after reset")

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// uyvy_pair_to_rgb testbench
// Drives UYVY groups through the converter with random gaps on both sides,
// switches the luma-only mode over the APB port between phases, and checks
// every result beat against a table pair or a BT.601 fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench
  import upr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // BT.601 terms in 1/1000 of a 1/32 unit
  localparam int Y_GAIN   = 37248;
  localparam int Y_BIAS_B = -8861696;
  localparam int Y_BIAS_G = 4335616;
  localparam int Y_BIAS_R = -7133184;
  localparam int U_TO_B   = 64576;
  localparam int U_TO_G   = -12512;
  localparam int V_TO_G   = -26016;
  localparam int V_TO_R   = 51072;
  localparam logic [7:0] MID_CHROMA = 8'd128;

  localparam logic [2:0] LUMA_ONLY_ADDR = {REG_LUMA_ONLY, 2'b00};
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 60;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 220;
  localparam int DIR_ROWS     = 19;

  typedef struct packed {
    rgb_t first;
    rgb_t second;
    logic second_valid;
  } pair_result_t;

  typedef struct packed {
    logic         luma;
    grp_t         grp;
    logic         typed;
    pair_result_t want;
  } dir_row_t;

  localparam rgb_t         BLACK_PX     = '0;
  localparam rgb_t         WHITE_PX     = '1;
  localparam rgb_t         ZERO_CODE_PX = '{8'd0, 8'd135, 8'd0};
  localparam rgb_t         FULL_CODE_PX = '{8'd255, 8'd125, 8'd255};
  localparam pair_result_t NO_WANT      = '0;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  upr_in_if  in_if ();
  upr_out_if out_if ();

  uyvy_pair_to_rgb dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_if),
    .out_beat (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shared state between the stimulus and result processes
  pair_result_t pairs_due [$];
  logic luma_mode;
  bit   idle_on;
  bit   hold_req;
  int   mismatches;
  int   strays;

  // Directed groups: extremes, bit toggles, odd tails, both modes
  dir_row_t stim_table [DIR_ROWS] = '{
    '{1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1,
      '{ZERO_CODE_PX, ZERO_CODE_PX, 1'b1}},
    '{1'b0, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b1,
      '{FULL_CODE_PX, FULL_CODE_PX, 1'b1}},
    '{1'b0, '{8'h80, 8'h00, 8'h80, 8'hFF, 1'b0}, 1'b1, '{BLACK_PX, WHITE_PX, 1'b1}},
    '{1'b0, '{8'h80, 8'hFF, 8'h80, 8'h00, 1'b1}, 1'b1, '{WHITE_PX, BLACK_PX, 1'b0}},
    '{1'b0, '{8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0}, 1'b0, NO_WANT},
    '{1'b0, '{8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0}, 1'b0, NO_WANT},
    '{1'b0, '{8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0}, 1'b0, NO_WANT},
    '{1'b0, '{8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1}, 1'b0, NO_WANT},
    '{1'b0, '{8'd16, 8'd16, 8'd240, 8'd235, 1'b0}, 1'b0, NO_WANT},
    '{1'b0, '{8'd240, 8'd235, 8'd16, 8'd16, 1'b0}, 1'b0, NO_WANT},
    '{1'b0, '{8'h00, 8'h80, 8'hFF, 8'h80, 1'b1}, 1'b0, NO_WANT},
    '{1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, '{BLACK_PX, BLACK_PX, 1'b1}},
    '{1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b1, '{WHITE_PX, WHITE_PX, 1'b1}},
    '{1'b1, '{8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1}, 1'b1, '{BLACK_PX, BLACK_PX, 1'b0}},
    '{1'b1, '{8'h00, 8'hFF, 8'hFF, 8'h00, 1'b1}, 1'b1, '{WHITE_PX, BLACK_PX, 1'b0}},
    '{1'b1, '{8'hAA, 8'd128, 8'h55, 8'd64, 1'b0}, 1'b0, NO_WANT},
    '{1'b1, '{8'h55, 8'd16, 8'hAA, 8'd235, 1'b0}, 1'b0, NO_WANT},
    '{1'b0, '{8'h80, 8'h80, 8'h80, 8'h80, 1'b0}, 1'b0, NO_WANT},
    '{1'b0, '{8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1}, 1'b0, NO_WANT}
  };

  // One term rounded to the nearest 1/32 (floor of x + 0.5)
  function automatic int term_32nds(input int gain, input int code, input int bias);
    int n;
    int q;
    n = gain * code + bias + 500;
    q = n / 1000;
    if (n < 0 && (n % 1000) != 0) q = q - 1;
    return q;
  endfunction

  // Floor divide by 32, clamp to a byte
  function automatic logic [7:0] clamp_channel(input int sum);
    int v;
    v = sum >>> 5;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic rgb_t luma_to_rgb(input logic [7:0] y, input int u_b, input int u_g,
                                       input int v_g, input int v_r);
    rgb_t px;
    px.blue  = clamp_channel(term_32nds(Y_GAIN, int'(y), Y_BIAS_B) + u_b);
    px.green = clamp_channel(term_32nds(Y_GAIN, int'(y), Y_BIAS_G) + u_g + v_g);
    px.red   = clamp_channel(term_32nds(Y_GAIN, int'(y), Y_BIAS_R) + v_r);
    return px;
  endfunction

  // Expected pixel pair for one group under the current mode
  function automatic pair_result_t predict_pair(input grp_t g, input logic grey);
    pair_result_t r;
    logic [7:0] u;
    logic [7:0] v;
    int u_b, u_g, v_g, v_r;
    u   = grey ? MID_CHROMA : g.cb;
    v   = grey ? MID_CHROMA : g.cr;
    u_b = term_32nds(U_TO_B, int'(u), 0);
    u_g = term_32nds(U_TO_G, int'(u), 0);
    v_g = term_32nds(V_TO_G, int'(v), 0);
    v_r = term_32nds(V_TO_R, int'(v), 0);
    r.first = luma_to_rgb(g.y0, u_b, u_g, v_g, v_r);
    if (g.one_pixel) begin
      r.second       = '0;
      r.second_valid = 1'b0;
    end else begin
      r.second       = luma_to_rgb(g.y1, u_b, u_g, v_g, v_r);
      r.second_valid = 1'b1;
    end
    return r;
  endfunction

  // Random byte, leaning on the rails now and then
  function automatic logic [7:0] draw_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one group; returns in the step of its acceptance edge
  task automatic offer_group(input grp_t g, input pair_result_t want);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.cb_byte   <= g.cb;
    in_if.y_first   <= g.y0;
    in_if.cr_byte   <= g.cr;
    in_if.y_second  <= g.y1;
    in_if.one_pixel <= g.one_pixel;
    do @(posedge clk); while (!in_if.ready);
    pairs_due.push_back(want);
  endtask

  // Let the pipeline empty out
  task automatic wait_drained();
    while (pairs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write of luma_only, then read back
  task automatic set_luma_mode(input logic mode);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LUMA_ONLY_ADDR;
    pwdata  <= {31'd0, mode};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    luma_mode = mode;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[0] !== mode) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("luma_only readback: expected %0b, got %0b", mode, rd[0]);
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("uyvy_pair_to_rgb regression: fail");
    $finish;
  end

  // Result side: random stalls, one long hold on request, check each beat
  initial begin
    int stall;
    pair_result_t got;
    pair_result_t want;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got.first        = '{out_if.blue_first, out_if.green_first, out_if.red_first};
      got.second       = '{out_if.blue_second, out_if.green_second, out_if.red_second};
      got.second_valid = out_if.second_valid;
      if (pairs_due.size() == 0) begin
        strays++;
        if (strays + mismatches <= MAX_REPORTS)
          $display("result beat with nothing pending: %h", got);
      end else begin
        want = pairs_due.pop_front();
        if (got !== want) begin
          mismatches++;
          // pixels shown as BBGGRR
          if (mismatches <= MAX_REPORTS)
            $display("pair mismatch: expected %h / %h v%b, got %h / %h v%b",
                     want.first, want.second, want.second_valid,
                     got.first, got.second, got.second_valid);
        end
      end
    end
  end

  // Stimulus
  initial begin
    grp_t g;
    pair_result_t want;
    logic [31:0] rd;
    mismatches = 0;
    strays     = 0;
    luma_mode  = 1'b0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    rst_n      <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_if.valid     <= 1'b0;
    in_if.cb_byte   <= '0;
    in_if.y_first   <= '0;
    in_if.cr_byte   <= '0;
    in_if.y_second  <= '0;
    in_if.one_pixel <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value of luma_only
    psel  <= 1'b1;
    paddr <= LUMA_ONLY_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[0] !== 1'b0) begin
      mismatches++;
      $display("luma_only after reset: expected 0, got %0b", rd[0]);
    end
    @(posedge clk);

    // Directed table
    foreach (stim_table[i]) begin
      if (stim_table[i].luma != luma_mode) begin
        in_if.valid <= 1'b0;
        wait_drained();
        set_luma_mode(stim_table[i].luma);
      end
      want = stim_table[i].typed ? stim_table[i].want
                                 : predict_pair(stim_table[i].grp, luma_mode);
      offer_group(stim_table[i].grp, want);
    end

    // Random phases, alternating the mode
    for (int ph = 0; ph < PHASES; ph++) begin
      in_if.valid <= 1'b0;
      wait_drained();
      set_luma_mode(ph % 2 == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
        // long receiver hold while groups keep coming
        if (ph == 1 && k == 60) hold_req = 1'b1;
        // sender pause until the pipeline is empty
        if (ph == 3 && k == 100) begin
          in_if.valid <= 1'b0;
          wait_drained();
        end
        g.cb        = draw_byte();
        g.y0        = draw_byte();
        g.cr        = draw_byte();
        g.y1        = draw_byte();
        g.one_pixel = ($urandom_range(0, 5) == 0);
        offer_group(g, predict_pair(g, luma_mode));
      end
    end

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && strays == 0 && pairs_due.size() == 0)
      $display("uyvy_pair_to_rgb regression: pass");
    else
      $display("uyvy_pair_to_rgb regression: fail");
    $finish;
  end

endmodule
